>>> hw/rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg: shared types and constants for the compass heading/sector core
// Fixed-point widths, arctangent table and the CORDIC pipeline payload.
// ----------------------------------------------------------------------------
`default_nettype none

package chs_pkg;

  // field widths
  localparam int IN_W   = 13;   // mag_x / mag_y
  localparam int HDG_W  = 13;   // heading, 1/16 degree
  localparam int SEC_W  = 3;    // compass sector
  localparam int DECL_W = 13;   // declination offset

  // CORDIC datapath: inputs scaled by 2^12, angle in 2^-16 degree
  localparam int IN_SCALE = 12;
  localparam int XY_W     = 28;
  localparam int Z_W      = 26;
  localparam int RND_W    = Z_W - IN_SCALE;   // rounded angle, 1/16 degree
  localparam int RAW_W    = RND_W + 1;        // angle plus declination
  localparam int WRAP_W   = RAW_W + 1;        // headroom for the wrap adds

  localparam int TABLE_LEN = 24;
  localparam int ATAN_W    = 22;

  // quarter turn, 2^-16 degree
  localparam logic signed [Z_W-1:0] QUARTER_Z = Z_W'(90 * 65536);
  // rounding bias before the drop to 1/16 degree
  localparam logic signed [Z_W-1:0] ROUND_Z   = Z_W'(2048);

  // heading geometry, 1/16 degree
  localparam int FULL_TURN   = 5760;
  localparam int HALF_SECTOR = 360;
  localparam int SECTOR_SPAN = 720;
  localparam int NUM_SECTORS = 8;

  // atan(2^-i) in degrees times 65536, rounded
  localparam logic [ATAN_W-1:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0
  };

  // payload carried through the rotation stages
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;   // both axes zero: angle forced to 0
  } cordic_t;

endpackage

`default_nettype wire

>>> hw/rtl/compass_heading_sector_core.sv
// Stages: one input fold stage, one stage per micro-rotation, three back-end stages.
// Throughput: one request per clock; every stage is a register with its own
//   valid bit, so bubbles close up and a stall holds each request in place.
// Reset: rst (synchronous) empties the pipeline and sets the declination to 88.
// ----------------------------------------------------------------------------
// compass_heading_sector_core: magnetometer compass heading and sector
// Pipelined CORDIC atan2 of an X/Y sample, declination add, wrap, 8-way sector.
// ----------------------------------------------------------------------------
`default_nettype none

module compass_heading_sector_core
  import chs_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // declination register write
  input  wire logic        cfg_wr_en,
  input  wire logic [12:0] cfg_wr_data,
  // sample requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [12:0] mag_x, [25:13] mag_y, rest zero
  // result requests
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [12:0] heading, [15:13] sector
);

  localparam int NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  logic signed [DECL_W-1:0] declination_offset;

  logic    stg_valid [0:NSTG];
  logic    stg_ready [0:NSTG];
  cordic_t stg_data  [0:NSTG];

  logic [HDG_W-1:0] heading;
  logic [SEC_W-1:0] sector;

  // declination register
  always_ff @(posedge clk) begin
    if (rst) begin
      declination_offset <= DECL_W'(88);
    end else if (cfg_wr_en) begin
      declination_offset <= cfg_wr_data;
    end
  end

  // input fold
  chs_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .mag_x     (s_axis_tdata[IN_W-1:0]),
    .mag_y     (s_axis_tdata[2*IN_W-1:IN_W]),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_data  (stg_data[0])
  );

  // micro-rotation chain
  for (genvar i = 0; i < NSTG; i++) begin : g_rot
    chs_cordic_stage #(
      .STAGE (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_data   (stg_data[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_data  (stg_data[i+1])
    );
  end

  // round, wrap, sector
  chs_post u_post (
    .clk                (clk),
    .rst                (rst),
    .declination_offset (declination_offset),
    .in_valid           (stg_valid[NSTG]),
    .in_ready           (stg_ready[NSTG]),
    .in_data            (stg_data[NSTG]),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .heading            (heading),
    .sector             (sector)
  );

  assign m_axis_tdata = {sector, heading};

  // heading never leaves one turn
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (heading < HDG_W'(FULL_TURN)))
    else $error("heading out of range");

  // north sector covers both ends of the turn
  a_north_sector: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (heading < HDG_W'(HALF_SECTOR)
                       || heading >= HDG_W'(FULL_TURN - HALF_SECTOR)))
    |-> (sector == '0))
    else $error("north sector mismatch");

  // a taken output frees the whole ready chain back to the input
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("ready chain blocked with output drained");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

>>> hw/rtl/chs_pre.sv
// ----------------------------------------------------------------------------
// chs_pre: input stage of the CORDIC pipeline
// Scales the sample, folds the left half plane by +/-90 degrees, flags zero.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_pre
  import chs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [IN_W-1:0] mag_x,
  input  wire logic signed [IN_W-1:0] mag_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output cordic_t                    out_data
);

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  cordic_t                data_next;

  assign in_ready = !out_valid || out_ready;

  // scale by 2^12 and rotate into the right half plane
  always_comb begin
    xs = {{(XY_W-IN_W-IN_SCALE){mag_x[IN_W-1]}}, mag_x, {IN_SCALE{1'b0}}};
    ys = {{(XY_W-IN_W-IN_SCALE){mag_y[IN_W-1]}}, mag_y, {IN_SCALE{1'b0}}};
    data_next.zero = (mag_x == '0) && (mag_y == '0);
    data_next.x    = xs;
    data_next.y    = ys;
    data_next.z    = '0;
    if (xs[XY_W-1]) begin
      if (!ys[XY_W-1]) begin
        data_next.x = ys;
        data_next.y = -xs;
        data_next.z = QUARTER_Z;
      end else begin
        data_next.x = -ys;
        data_next.y = xs;
        data_next.z = -QUARTER_Z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/chs_cordic_stage.sv
// ----------------------------------------------------------------------------
// chs_cordic_stage: one vectoring micro-rotation, registered
// Drives y toward zero and accumulates the matching arctangent into z.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_cordic_stage
  import chs_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire cordic_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output cordic_t      out_data
);

  localparam logic signed [Z_W-1:0] ATAN_Z =
    Z_W'({{(Z_W-ATAN_W){1'b0}}, ATAN_TABLE[STAGE]});

  logic signed [XY_W-1:0] x_sh;
  logic signed [XY_W-1:0] y_sh;
  cordic_t                data_next;

  assign in_ready = !out_valid || out_ready;

  // floor shifts, direction from the sign of y
  always_comb begin
    x_sh           = in_data.x >>> STAGE;
    y_sh           = in_data.y >>> STAGE;
    data_next.zero = in_data.zero;
    if (!in_data.y[XY_W-1]) begin
      data_next.x = in_data.x + y_sh;
      data_next.y = in_data.y - x_sh;
      data_next.z = in_data.z + ATAN_Z;
    end else begin
      data_next.x = in_data.x - y_sh;
      data_next.y = in_data.y + x_sh;
      data_next.z = in_data.z - ATAN_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/chs_post.sv
// ----------------------------------------------------------------------------
// chs_post: heading back end, three register stages
// Round and add declination, wrap into one turn, then pick the sector.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_post
  import chs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic signed [DECL_W-1:0] declination_offset,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire cordic_t                 in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [HDG_W-1:0]             heading,
  output logic [SEC_W-1:0]             sector
);

  // stage A: rounded angle plus declination
  logic                     raw_valid;
  logic                     raw_ready;
  logic signed [RAW_W-1:0]  raw_hdg;
  logic signed [Z_W-1:0]    z_bias;
  logic signed [RAW_W-1:0]  raw_next;

  // stage B: wrapped heading
  logic                     wrap_valid;
  logic                     wrap_ready;
  logic [HDG_W-1:0]         wrap_hdg;
  logic signed [WRAP_W-1:0] raw_ext;
  logic signed [WRAP_W-1:0] wrap_next;

  logic [SEC_W-1:0]         sector_next;

  assign in_ready   = !raw_valid || raw_ready;
  assign raw_ready  = !wrap_valid || wrap_ready;
  assign wrap_ready = !out_valid || out_ready;

  // round to 1/16 degree (floor shift after bias), add declination
  always_comb begin
    z_bias   = (in_data.zero ? '0 : in_data.z) + ROUND_Z;
    raw_next = {z_bias[Z_W-1], z_bias[Z_W-1:IN_SCALE]}
             + {{(RAW_W-DECL_W){declination_offset[DECL_W-1]}}, declination_offset};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
    end else if (in_ready) begin
      raw_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw_hdg <= raw_next;
    end
  end

  // wrap into [0, FULL_TURN): at most two turns below, one above
  always_comb begin
    raw_ext = {raw_hdg[RAW_W-1], raw_hdg};
    if (raw_ext < -WRAP_W'(FULL_TURN)) begin
      wrap_next = raw_ext + WRAP_W'(2 * FULL_TURN);
    end else if (raw_ext < 0) begin
      wrap_next = raw_ext + WRAP_W'(FULL_TURN);
    end else if (raw_ext >= WRAP_W'(FULL_TURN)) begin
      wrap_next = raw_ext - WRAP_W'(FULL_TURN);
    end else begin
      wrap_next = raw_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_valid <= 1'b0;
    end else if (raw_ready) begin
      wrap_valid <= raw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_valid && raw_ready) begin
      wrap_hdg <= wrap_next[HDG_W-1:0];
    end
  end

  // sector boundaries at half a sector plus whole sectors; top one folds to N
  always_comb begin
    sector_next = '0;
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (wrap_hdg >= HDG_W'(k * SECTOR_SPAN - HALF_SECTOR)) begin
        sector_next = SEC_W'(k);
      end
    end
    if (wrap_hdg >= HDG_W'(FULL_TURN - HALF_SECTOR)) begin
      sector_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wrap_ready) begin
      out_valid <= wrap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wrap_valid && wrap_ready) begin
      heading <= wrap_hdg;
      sector  <= sector_next;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/compass_heading_sector_core_test.sv
// ----------------------------------------------------------------------------
// compass_heading_sector_core_test: self-checking bench for the compass core
// Streams X/Y samples through the core and compares heading and sector with a
// bit-exact CORDIC predictor. It covers axis and corner samples, declination
// extremes and the full-turn wrap, then random traffic under three idle mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module compass_heading_sector_core_test
  import chs_pkg::*;
();

  // must track the core's CORDIC_STAGES (default)
  localparam int ROT_STEPS = 16;
  localparam int ROT_TABLE = 24;
  localparam int PIPE_LAT  = ROT_STEPS + 4;

  // expected heading/sector for one sample
  typedef struct {
    logic signed [IN_W-1:0] mag_x;
    logic signed [IN_W-1:0] mag_y;
    logic [HDG_W-1:0]       heading;
    logic [SEC_W-1:0]       sector;
  } bearing_t;

  // atan(2^-i) in 2^-16 degree, rounded
  longint arc_deg16 [0:ROT_TABLE-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [12:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [12:0] mag_x, [25:13] mag_y, rest zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [12:0] heading, [15:13] sector

  bearing_t         bearings_due [$];
  logic [DECL_W-1:0] decl_now = 13'd88;
  int               src_idle_pct = 0;
  int               snk_idle_pct = 0;
  int               err_count = 0;

  compass_heading_sector_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // bit-exact heading: vectoring CORDIC, round, add declination, wrap, sector
  function automatic bearing_t compass_bearing(logic signed [IN_W-1:0] mx,
                                               logic signed [IN_W-1:0] my,
                                               logic [DECL_W-1:0] decl);
    bearing_t res;
    longint   vx, vy, ang, t, sx, sy, hdg;
    int       steps;
    vx = longint'(mx) * 4096;
    vy = longint'(my) * 4096;
    ang = 0;
    steps = (ROT_STEPS > ROT_TABLE) ? ROT_TABLE : ROT_STEPS;
    if (mx != 0 || my != 0) begin
      // fold the left half plane by a quarter turn
      if (vx < 0) begin
        if (vy >= 0) begin
          t = vx; vx = vy; vy = -t; ang = 90 * 65536;
        end else begin
          t = vx; vx = -vy; vy = t; ang = -90 * 65536;
        end
      end
      for (int i = 0; i < steps; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (vy >= 0) begin
          vx = vx + sy; vy = vy - sx; ang = ang + arc_deg16[i];
        end else begin
          vx = vx - sy; vy = vy + sx; ang = ang - arc_deg16[i];
        end
      end
    end
    hdg = ((ang + 2048) >>> 12) + longint'($signed(decl));
    hdg = hdg % FULL_TURN;
    if (hdg < 0) hdg = hdg + FULL_TURN;
    res.mag_x   = mx;
    res.mag_y   = my;
    res.heading = HDG_W'(hdg);
    res.sector  = SEC_W'((hdg + HALF_SECTOR) / SECTOR_SPAN);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want, int mx, int my);
    err_count++;
    $display("ERROR %s: got %0d want %0d (mag_x %0d mag_y %0d)",
             what, got, want, mx, my);
  endtask

  // one sample request, with random idle cycles ahead of it
  task automatic send_sample(logic signed [IN_W-1:0] mx, logic signed [IN_W-1:0] my);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, my, mx};
    do @(posedge clk); while (!s_axis_tready);
    bearings_due.push_back(compass_bearing(mx, my, decl_now));
  endtask

  // stop sending and wait until every pending result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (bearings_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_declination(logic [DECL_W-1:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    decl_now  = v;
  endtask

  // result side: random stalls and in-order check
  always @(posedge clk) begin
    bearing_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (bearings_due.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0, 0, 0);
      end else begin
        want = bearings_due.pop_front();
        if (m_axis_tdata[12:0] !== want.heading)
          report_mismatch("heading", m_axis_tdata[12:0], want.heading,
                          want.mag_x, want.mag_y);
        if (m_axis_tdata[15:13] !== want.sector)
          report_mismatch("sector", m_axis_tdata[15:13], want.sector,
                          want.mag_x, want.mag_y);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // random sample: full range, tiny vectors, on an axis or on a diagonal
  task automatic pick_sample(output logic signed [IN_W-1:0] mx,
                             output logic signed [IN_W-1:0] my);
    int kind;
    kind = $urandom_range(9);
    mx = IN_W'($urandom_range(8191));
    my = IN_W'($urandom_range(8191));
    case (kind)
      5, 6: begin
        mx = IN_W'($signed($urandom_range(16)) - 8);
        my = IN_W'($signed($urandom_range(16)) - 8);
      end
      7: begin
        if ($urandom_range(1)) mx = '0;
        else my = '0;
      end
      8: begin
        my = $urandom_range(1) ? mx : -mx;
      end
      default: ;
    endcase
  endtask

  // axes, corners, zero vector, left half plane folds at reset declination
  task automatic test_axes_and_corners();
    send_sample(13'sd0, 13'sd0);
    send_sample(13'sd4095, 13'sd0);
    send_sample(-13'sd4096, 13'sd0);
    send_sample(13'sd0, 13'sd4095);
    send_sample(13'sd0, -13'sd4096);
    send_sample(13'sd4095, 13'sd4095);
    send_sample(-13'sd4096, -13'sd4096);
    send_sample(-13'sd4096, 13'sd4095);
    send_sample(13'sd4095, -13'sd4096);
    send_sample(-13'sd1, 13'sd0);
    send_sample(-13'sd1, -13'sd1);
    send_sample(-13'sd1, 13'sd1);
    send_sample(13'sd1, -13'sd1);
    send_sample(-13'sd4096, -13'sd1);
    send_sample(13'sd1, 13'sd0);
  endtask

  // declination limits, out-of-range values and the exact full turn
  task automatic test_declination_extremes();
    set_declination(13'sd0);
    send_sample(13'sd0, 13'sd0);
    set_declination(13'sd2879);
    send_sample(13'sd0, 13'sd0);
    send_sample(-13'sd4096, 13'sd0);
    set_declination(-13'sd2880);
    send_sample(13'sd0, 13'sd0);
    send_sample(-13'sd4096, -13'sd1);
    set_declination(13'sd2880);
    send_sample(-13'sd4096, 13'sd0);
    send_sample(-13'sd1, 13'sd0);
    set_declination(13'sd4095);
    send_sample(13'sd0, 13'sd0);
    send_sample(-13'sd4096, 13'sd0);
    set_declination(-13'sd4096);
    send_sample(13'sd0, 13'sd0);
  endtask

  // random samples; declination changes every so often between bursts
  task automatic test_random_traffic(int count, int src_pct, int snk_pct);
    logic signed [IN_W-1:0] mx, my;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 160 == 0) begin
        if ($urandom_range(3) == 0)
          set_declination($urandom_range(1) ? 13'sd2879 : -13'sd2880);
        else
          set_declination(DECL_W'($urandom_range(8191)));
      end
      pick_sample(mx, my);
      send_sample(mx, my);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_axes_and_corners();
    test_declination_extremes();
    set_declination(13'sd88);
    test_random_traffic(630, 21, 84);
    test_random_traffic(630, 84, 21);
    test_random_traffic(640, 0, 0);
    drain_results();
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (err_count == 0)
      $display("compass_heading_sector_core: match");
    else
      $display("compass_heading_sector_core: mismatch");
    $finish;
  end

  // run time guard
  initial begin
    #5000000;
    $display("compass_heading_sector_core: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
